// ===== hw/rtl/atsp_pkg.sv =====
package atsp_pkg;

  localparam int OFFSET_W   = 16;
  localparam int GAIN_W     = 2;
  localparam int COEFF_W    = 16;
  localparam int DIM_W      = 12;
  localparam int POS_W      = 12;
  localparam int POSZ_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int Z_TOP      = 500;
  localparam int Z_BOTTOM   = 5;
  localparam int Z_MID      = Z_TOP / 2;
  localparam int POS_TOP    = 4095;

  localparam logic [GAIN_W-1:0]  GAIN_DOUBLE         = 2'd2;
  localparam logic [GAIN_W-1:0]  GAIN_RESET          = 2'd1;
  localparam logic [COEFF_W-1:0] COEFF_RESET         = 16'd1638;
  localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RESET  = 12'd1280;
  localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RESET = 12'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_OFFSET_Z      = 3'd2,
    REG_GAIN          = 3'd3,
    REG_FILTER_COEFF  = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6
  } cfg_reg_t;

endpackage

// ===== hw/rtl/atsp_if.sv =====
interface atsp_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] raw_x;
  logic signed [SAMPLE_WIDTH-1:0] raw_y;
  logic signed [SAMPLE_WIDTH-1:0] raw_z;

  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface atsp_out_if import atsp_pkg::*; #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filt_x;
  logic signed [SAMPLE_WIDTH-1:0] filt_y;
  logic signed [SAMPLE_WIDTH-1:0] filt_z;
  logic        [POS_W-1:0]        pos_x;
  logic        [POS_W-1:0]        pos_y;
  logic        [POSZ_W-1:0]       pos_z;

  modport source (output valid, filt_x, filt_y, filt_z, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, filt_x, filt_y, filt_z, pos_x, pos_y, pos_z, output ready);
endinterface

interface atsp_cfg_if import atsp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/accel_tilt_to_screen_position.sv =====
// a result word is registered and valid in the cycle after its sample word is accepted
// one word per cycle while results are taken; the per-axis filter multiply-add on the state
// register sets the cycle, the position clamps follow from the filter registers
// a stalled result holds the filter state, and input is taken again once it leaves
// reset (rst, synchronous): filter state cleared, no result pending, registers
// back to their reset values; the configuration port is always ready
module accel_tilt_to_screen_position import atsp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  atsp_in_if.sink    sample,
  atsp_out_if.source result,
  atsp_cfg_if.sink   cfg
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = ((SW > DIM_W) ? SW : DIM_W) + 3;

  logic signed [OFFSET_W-1:0] offset_x;
  logic signed [OFFSET_W-1:0] offset_y;
  logic signed [OFFSET_W-1:0] offset_z;
  logic        [GAIN_W-1:0]   gain;
  logic        [COEFF_W-1:0]  filter_coeff;
  logic        [DIM_W-1:0]    screen_width;
  logic        [DIM_W-1:0]    screen_height;

  logic                 out_valid;
  logic                 accept;
  logic                 dbl;
  logic signed [SW-1:0] acc_x;
  logic signed [SW-1:0] acc_y;
  logic signed [SW-1:0] acc_z;

  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [PW-1:0] pz;
  logic signed [PW-1:0] half;
  logic signed [PW-1:0] size_x;
  logic signed [PW-1:0] size_y;
  logic [POSZ_W-1:0]    pos_z_v;

  function automatic logic [POS_W-1:0] clamp_edge(logic signed [PW-1:0] p_in,
                                                  logic signed [PW-1:0] w,
                                                  logic signed [PW-1:0] size);
    logic signed [PW-1:0] p;
    p = p_in;
    if (p + w > size) begin
      p = size - w;
    end
    if (p + w < PW'(0)) begin
      p = w;
    end
    priority if (p < PW'(0)) begin
      return POS_W'(0);
    end else if (p > PW'(POS_TOP)) begin
      return POS_W'(POS_TOP);
    end else begin
      return p[POS_W-1:0];
    end
  endfunction

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      offset_z      <= '0;
      gain          <= GAIN_RESET;
      filter_coeff  <= COEFF_RESET;
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_OFFSET_X:      offset_x      <= cfg.data;
        REG_OFFSET_Y:      offset_y      <= cfg.data;
        REG_OFFSET_Z:      offset_z      <= cfg.data;
        REG_GAIN:          gain          <= cfg.data[GAIN_W-1:0];
        REG_FILTER_COEFF:  filter_coeff  <= cfg.data;
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg.data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the filter registers double as the result register
  assign sample.ready = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;
  assign dbl          = (gain == GAIN_DOUBLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  atsp_axis #(.SAMPLE_WIDTH(SW)) u_axis_x (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .raw    (sample.raw_x),
    .offset (offset_x),
    .dbl    (dbl),
    .neg    (1'b1),
    .coeff  (filter_coeff),
    .acc    (acc_x)
  );

  atsp_axis #(.SAMPLE_WIDTH(SW)) u_axis_y (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .raw    (sample.raw_y),
    .offset (offset_y),
    .dbl    (dbl),
    .neg    (1'b0),
    .coeff  (filter_coeff),
    .acc    (acc_y)
  );

  atsp_axis #(.SAMPLE_WIDTH(SW)) u_axis_z (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .raw    (sample.raw_z),
    .offset (offset_z),
    .dbl    (dbl),
    .neg    (1'b0),
    .coeff  (filter_coeff),
    .acc    (acc_z)
  );

  // cube position from the filtered values
  assign size_x = PW'(screen_width);
  assign size_y = PW'(screen_height);
  assign px     = PW'(acc_x) + PW'(screen_width[DIM_W-1:1]);
  assign py     = PW'(acc_y) + PW'(screen_height[DIM_W-1:1]);
  assign pz     = PW'(acc_z) + PW'(Z_MID);
  assign half   = (pz > PW'(0)) ? (pz >>> 1) : PW'(0);

  always_comb begin
    priority if (pz > PW'(Z_TOP)) begin
      pos_z_v = POSZ_W'(Z_TOP);
    end else if (pz < PW'(Z_BOTTOM)) begin
      pos_z_v = POSZ_W'(Z_BOTTOM);
    end else begin
      pos_z_v = pz[POSZ_W-1:0];
    end
  end

  assign result.valid  = out_valid;
  assign result.filt_x = acc_x;
  assign result.filt_y = acc_y;
  assign result.filt_z = acc_z;
  assign result.pos_x  = clamp_edge(px, half, size_x);
  assign result.pos_y  = clamp_edge(py, half, size_y);
  assign result.pos_z  = pos_z_v;

endmodule

// ===== hw/rtl/atsp_axis.sv =====
module atsp_axis import atsp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] raw,
  input  logic signed [OFFSET_W-1:0]     offset,
  input  logic                           dbl,
  input  logic                           neg,
  input  logic        [COEFF_W-1:0]      coeff,
  output logic signed [SAMPLE_WIDTH-1:0] acc
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = SW + 18;

  logic signed [SW-1:0] off_sw;
  logic signed [SW-1:0] diff_in;
  logic signed [SW-1:0] dbl_v;
  logic signed [SW-1:0] scaled_v;
  logic signed [SW:0]   delta;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] acc_sh;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] sum_adj;
  logic signed [SW-1:0] acc_next;

  // offset removal and sensitivity, wrapping to the sample width
  assign off_sw   = SW'(offset);
  assign diff_in  = raw - off_sw;
  assign dbl_v    = dbl ? {diff_in[SW-2:0], 1'b0} : diff_in;
  assign scaled_v = neg ? -dbl_v : dbl_v;

  // acc*(1-c) + new*c rewritten as acc + (new-acc)*c, c in Q0.16
  assign delta   = {scaled_v[SW-1], scaled_v} - {acc[SW-1], acc};
  assign prod    = delta * $signed({1'b0, coeff});
  assign acc_sh  = {{2{acc[SW-1]}}, acc, 16'h0000};
  assign sum     = acc_sh + prod;
  // truncate toward zero
  assign sum_adj = sum[AW-1] ? sum + AW'(16'hFFFF) : sum;
  assign acc_next = sum_adj[SW+15:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== hw/rtl/atsp_checker.sv =====
module atsp_checker import atsp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  pos_x,
  input logic [POSZ_W-1:0] pos_z
);

  // a stalled result word stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_z))
    else $error("stalled result word changed");

  // every accepted sample word shows up as a result word next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // a single result slot: no new word while one is stuck
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("word taken while result stalled");

  // depth stays inside its clamp
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos_z >= POSZ_W'(Z_BOTTOM)) && (pos_z <= POSZ_W'(Z_TOP)))
    else $error("pos_z outside clamp");

  // nothing pending straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind accel_tilt_to_screen_position atsp_checker u_atsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .pos_x     (result.pos_x),
  .pos_z     (result.pos_z)
);

// ===== tb/tb_accel_tilt_to_screen_position.sv =====
module tb_accel_tilt_to_screen_position;
  timeunit 1ns;
  timeprecision 1ps;

  import atsp_pkg::*;

  localparam int SW          = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RUN_ITEMS   = 430;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t RAW_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t RAW_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    sample_t           fx;
    sample_t           fy;
    sample_t           fz;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POSZ_W-1:0] pz;
  } tilt_t;

  typedef struct {
    bit                    is_cfg;
    bit                    typed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               rx;
    sample_t               ry;
    sample_t               rz;
    tilt_t                 want;
  } plan_row_t;

  logic clk;
  logic rst;

  atsp_in_if  #(.SAMPLE_WIDTH(SW)) sample_bus ();
  atsp_out_if #(.SAMPLE_WIDTH(SW)) result_bus ();
  atsp_cfg_if                      cfg_bus ();

  accel_tilt_to_screen_position #(.SAMPLE_WIDTH(SW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // predictor copy of the registers and filter state
  logic [OFFSET_W-1:0] off_x_q  = '0;
  logic [OFFSET_W-1:0] off_y_q  = '0;
  logic [OFFSET_W-1:0] off_z_q  = '0;
  logic [GAIN_W-1:0]   gain_q   = GAIN_RESET;
  logic [COEFF_W-1:0]  coeff_q  = COEFF_RESET;
  logic [DIM_W-1:0]    width_q  = SCREEN_WIDTH_RESET;
  logic [DIM_W-1:0]    height_q = SCREEN_HEIGHT_RESET;
  sample_t             fx_q     = '0;
  sample_t             fy_q     = '0;
  sample_t             fz_q     = '0;

  tilt_t     tilt_due[$];
  plan_row_t plan[$];
  int        errors        = 0;
  int        send_idle_pct = 8;
  int        recv_idle_pct = 58;
  int        cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sample_t scale_axis(sample_t raw, sample_t off, bit negate);
    longint d;
    d = (longint'(raw) - longint'(off)) * ((gain_q == GAIN_DOUBLE) ? 2 : 1);
    if (negate) d = -d;
    return d[SW-1:0];
  endfunction

  function automatic sample_t iir_step(sample_t acc, sample_t smp);
    longint c;
    longint s;
    c = longint'({48'd0, coeff_q});
    s = longint'(acc) * (65536 - c) + longint'(smp) * c;
    if (s < 0) s = -((-s) >>> 16);
    else s = s >>> 16;
    return s[SW-1:0];
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(longint p, longint w, longint size);
    if (p + w > size) p = size - w;
    if (p + w < 0) p = w;
    if (p < 0) return '0;
    if (p > POS_TOP) return POS_W'(POS_TOP);
    return p[POS_W-1:0];
  endfunction

  function automatic tilt_t next_tilt(sample_t rx, sample_t ry, sample_t rz);
    tilt_t  t;
    longint px;
    longint py;
    longint pz;
    longint w;
    fx_q = iir_step(fx_q, scale_axis(rx, off_x_q, 1'b1));
    fy_q = iir_step(fy_q, scale_axis(ry, off_y_q, 1'b0));
    fz_q = iir_step(fz_q, scale_axis(rz, off_z_q, 1'b0));
    px = longint'(fx_q) + longint'(width_q >> 1);
    py = longint'(fy_q) + longint'(height_q >> 1);
    pz = longint'(fz_q) + Z_MID;
    w  = (pz > 0) ? pz / 2 : 0;
    if (pz > Z_TOP) pz = Z_TOP;
    if (pz < Z_BOTTOM) pz = Z_BOTTOM;
    t.fx = fx_q;
    t.fy = fy_q;
    t.fz = fz_q;
    t.px = clamp_pos(px, w, longint'(width_q));
    t.py = clamp_pos(py, w, longint'(height_q));
    t.pz = pz[POSZ_W-1:0];
    return t;
  endfunction

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_sample(sample_t rx, sample_t ry, sample_t rz,
                                      bit typed = 1'b0, tilt_t want = '0);
    plan_row_t r;
    r       = '{default: '0};
    r.rx    = rx;
    r.ry    = ry;
    r.rz    = rz;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic sample_t pick_raw();
    sample_t v;
    case ($urandom_range(7))
      0: v = RAW_MAX;
      1: v = RAW_MIN;
      2: v = sample_t'($urandom_range(1023)) - sample_t'(512);
      default: v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(6))
      0: v = '0;
      1: v = '1;
      2: v = {1'b1, {(CFG_DATA_W-1){1'b0}}};
      3: v = {1'b0, {(CFG_DATA_W-1){1'b1}}};
      4: v = CFG_DATA_W'($urandom_range(255));
      default: v = CFG_DATA_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_OFFSET_X:      off_x_q  = val;
      REG_OFFSET_Y:      off_y_q  = val;
      REG_OFFSET_Z:      off_z_q  = val;
      REG_GAIN:          gain_q   = val[GAIN_W-1:0];
      REG_FILTER_COEFF:  coeff_q  = val;
      REG_SCREEN_WIDTH:  width_q  = val[DIM_W-1:0];
      REG_SCREEN_HEIGHT: height_q = val[DIM_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (tilt_due.size() != 0);
  endtask

  task automatic send_sample(sample_t rx, sample_t ry, sample_t rz, bit typed, tilt_t want);
    tilt_t pred;
    sample_bus.valid <= 1'b1;
    sample_bus.raw_x <= rx;
    sample_bus.raw_y <= ry;
    sample_bus.raw_z <= rz;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    pred = next_tilt(rx, ry, rz);
    tilt_due.push_back(typed ? want : pred);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic retune();
    drain_results();
    write_reg(REG_OFFSET_X, pick_word());
    write_reg(REG_OFFSET_Y, pick_word());
    write_reg(REG_OFFSET_Z, pick_word());
    write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(3)));
    write_reg(REG_FILTER_COEFF, ($urandom_range(2) == 0) ? pick_word() : CFG_DATA_W'($urandom));
    write_reg(REG_SCREEN_WIDTH, pick_word());
    write_reg(REG_SCREEN_HEIGHT, pick_word());
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_result
    tilt_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (tilt_due.size() == 0) begin
        errors++;
        $display("%0t ns: result word with none expected, expected nothing, actual %h",
                 $time, {result_bus.filt_x, result_bus.filt_y, result_bus.filt_z,
                         result_bus.pos_x, result_bus.pos_y, result_bus.pos_z});
      end else begin
        want = tilt_due.pop_front();
        check_field("filt_x", want.fx, result_bus.filt_x);
        check_field("filt_y", want.fy, result_bus.filt_y);
        check_field("filt_z", want.fz, result_bus.filt_z);
        check_field("pos_x", want.px, result_bus.pos_x);
        check_field("pos_y", want.py, result_bus.pos_y);
        check_field("pos_z", want.pz, result_bus.pos_z);
      end
    end
  end

  always @(posedge clk) result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tilt_t at_rest;
    int    n;
    int    send_pct[3];
    int    recv_pct[3];

    send_pct = '{8, 58, 0};
    recv_pct = '{58, 8, 0};

    // zero sample straight after reset lands at screen centre
    at_rest.fx = '0;
    at_rest.fy = '0;
    at_rest.fz = '0;
    at_rest.px = SCREEN_WIDTH_RESET >> 1;
    at_rest.py = SCREEN_HEIGHT_RESET >> 1;
    at_rest.pz = POSZ_W'(Z_MID);

    plan_sample(0, 0, 0, 1'b1, at_rest);
    plan_sample(RAW_MAX, RAW_MIN, RAW_MAX);
    plan_sample(RAW_MIN, RAW_MAX, RAW_MIN);
    plan_cfg(REG_GAIN, 16'd2);
    plan_sample(RAW_MAX, RAW_MAX, RAW_MAX);
    plan_sample(RAW_MIN, RAW_MIN, RAW_MIN);
    // full-weight filter drives positions negative
    plan_cfg(REG_FILTER_COEFF, 16'hFFFF);
    plan_sample(16384, -16384, RAW_MIN);
    plan_sample(RAW_MIN, RAW_MIN, RAW_MAX);
    plan_cfg(REG_OFFSET_X, 16'h8000);
    plan_cfg(REG_OFFSET_Y, 16'h7FFF);
    plan_cfg(REG_OFFSET_Z, 16'h8000);
    plan_sample(RAW_MAX, RAW_MIN, RAW_MAX);
    plan_sample(0, 0, 0);
    // out-of-range gain codes act as unity
    plan_cfg(REG_GAIN, 16'd0);
    plan_sample(100, -100, 200);
    plan_cfg(REG_GAIN, 16'd3);
    plan_sample(-100, 100, -200);
    // zero weight holds the filter
    plan_cfg(REG_FILTER_COEFF, 16'd0);
    plan_sample(1234, -4321, 777);
    plan_cfg(REG_SCREEN_WIDTH, 16'd0);
    plan_cfg(REG_SCREEN_HEIGHT, 16'd0);
    plan_cfg(REG_FILTER_COEFF, 16'hFFFF);
    plan_sample(-5000, 5000, 300);
    plan_cfg(REG_SCREEN_WIDTH, 16'hFFFF);
    plan_cfg(REG_SCREEN_HEIGHT, 16'hFFFF);
    plan_cfg(REG_OFFSET_X, 16'd0);
    plan_cfg(REG_OFFSET_Y, 16'd0);
    plan_cfg(REG_OFFSET_Z, 16'd0);
    plan_cfg(REG_GAIN, 16'd1);
    plan_cfg(REG_UNUSED, 16'hFFFF);
    // deep negative x with large z pushes the position past the top
    plan_sample(RAW_MAX, 0, RAW_MAX);
    plan_sample(RAW_MIN, RAW_MIN, RAW_MAX);
    plan_cfg(REG_SCREEN_WIDTH, 16'd1);
    plan_cfg(REG_SCREEN_HEIGHT, 16'd1);
    plan_cfg(REG_FILTER_COEFF, 16'd1638);
    plan_sample(0, 0, 0);
    plan_sample(RAW_MAX, RAW_MAX, 0);

    sample_bus.valid = 1'b0;
    sample_bus.raw_x = '0;
    sample_bus.raw_y = '0;
    sample_bus.raw_z = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    result_bus.ready = 1'b0;
    rst              = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].rx, plan[i].ry, plan[i].rz, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      retune();
      for (n = 0; n < RUN_ITEMS; n++) begin
        if (n % 100 == 99) retune();
        send_sample(pick_raw(), pick_raw(), pick_raw(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
